FILE: rtl/lbd_pkg.sv
`timescale 1ns / 1ps
// lbd_pkg: sizes, codes and helper functions of the luma box downsampler
// depends on nothing; imported by luma_box_downsampler

package lbd_pkg;

    // output grid and largest source dimension
    localparam int OUT_W       = 64;
    localparam int OUT_H       = 48;
    localparam int MAX_SRC_DIM = 2048;

    // fixed field widths
    localparam int CFG_W       = 12;
    localparam int PIX_W       = 32;
    localparam int LUMA_W      = 8;
    localparam int GRAY_W      = 8;
    localparam int COORD_W     = 6;
    localparam int SUM_W       = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_FIELD_W = GRAY_W + 2 * COORD_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // derived widths
    localparam int DIM_W     = $clog2(MAX_SRC_DIM + 1);
    localparam int COL_W     = $clog2(OUT_W + 1);
    localparam int ROW_W     = $clog2(OUT_H + 1);
    localparam int ADDR_W    = (OUT_W > 1) ? $clog2(OUT_W) : 1;
    localparam int AREA_W    = 2 * DIM_W;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // reciprocal scaling for the block size, exact for every dimension in range
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] SX_RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + OUT_W - 1) / OUT_W);
    localparam logic [RECIP_W-1:0] SY_RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + OUT_H - 1) / OUT_H);

    // dimensions after reset
    localparam int RESET_W_RAW = 320;
    localparam int RESET_H_RAW = 200;
    localparam int RESET_W     = (RESET_W_RAW > MAX_SRC_DIM) ? MAX_SRC_DIM : RESET_W_RAW;
    localparam int RESET_H     = (RESET_H_RAW > MAX_SRC_DIM) ? MAX_SRC_DIM : RESET_H_RAW;
    localparam logic [DIM_W-1:0] RESET_SRC_W = DIM_W'(RESET_W);
    localparam logic [DIM_W-1:0] RESET_SRC_H = DIM_W'(RESET_H);
    localparam logic [DIM_W-1:0] RESET_SX    = DIM_W'(RESET_W / OUT_W);
    localparam logic [DIM_W-1:0] RESET_SY    = DIM_W'(RESET_H / OUT_H);

    // luma weights and output bias
    localparam logic [7:0] LUMA_R_WT = 8'd77;
    localparam logic [7:0] LUMA_G_WT = 8'd150;
    localparam logic [7:0] LUMA_B_WT = 8'd29;
    localparam logic [GRAY_W-1:0] GRAY_BIAS = GRAY_W'(128);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 1'b0,
        CFG_SRC_HEIGHT = 1'b1
    } t_cfg_index;

    // control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_DIV,
        S_OUT
    } t_state;

    // limit a written dimension to the supported maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [31:0] v_ext;
        v_ext = 32'(v);
        if (v_ext > 32'(MAX_SRC_DIM)) begin
            return DIM_W'(MAX_SRC_DIM);
        end
        return DIM_W'(v_ext);
    endfunction

    // dimension divided by the grid size, via the scaled reciprocal
    function automatic logic [DIM_W-1:0] scale_dim(input logic [DIM_W-1:0] w,
                                                   input logic [RECIP_W-1:0] recip);
        logic [DIM_W+RECIP_W-1:0] prod;
        prod = (DIM_W + RECIP_W)'(w) * (DIM_W + RECIP_W)'(recip);
        return prod[RECIP_SHIFT +: DIM_W];
    endfunction

    // 8-bit luma of one source pixel
    function automatic logic [LUMA_W-1:0] luma_of(input logic [PIX_W-1:0] word);
        logic [15:0] acc;
        acc = 16'(word[23:16]) * 16'(LUMA_R_WT)
            + 16'(word[15:8])  * 16'(LUMA_G_WT)
            + 16'(word[7:0])   * 16'(LUMA_B_WT);
        return acc[15:8];
    endfunction

endpackage

FILE: rtl/luma_box_downsampler.sv
`timescale 1ns / 1ps
// luma_box_downsampler: top level, pixel counters, accumulator update and divider
// depends on lbd_pkg and lbd_ram

// Usage
//   Source pixels enter on the s_axis channel in raster order, one 32-bit word
//   each (red 23..16, green 15..8, blue 7..0). Block means, less 128, leave on
//   the m_axis channel as gray value, output column and row; tlast marks the
//   last block of a frame. The cfg channel writes source width (index 0) and
//   source height (index 1); write them only while no pixel is in flight.
//   Sequence: a pixel that closes no block is accepted, then gets one
//   read-modify-write of its column sum in the accumulator RAM, whose read
//   data is registered. A pixel that closes a block then passes through the
//   bit-serial divider (one quotient bit per cycle) and the load of the
//   output word. Pixels outside the last whole block column or row, and every
//   pixel while either block size is zero, are counted only and can be taken
//   on back-to-back cycles.
//   Reset sets 320 x 200, clears all counters and the output valid flag; the
//   column sums are undefined until a block's first pixel overwrites them, so
//   there is no clearing pass.
//   A stalled receiver holds the output word; the next pixels are still taken
//   until another block result has to be loaded, which then waits.

module luma_box_downsampler
    import lbd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side: pixel_word
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [PIX_W-1:0]       i_s_axis_tdata,     // [31:0] pixel_word
    // master side: block result
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,     // [7:0] gray_value, [13:8] out_col,
                                                       // [19:14] out_row, [23:20] zero
    output logic                   o_m_axis_tlast,     // frame_done
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    // configuration and derived block size
    logic [DIM_W-1:0]  r_src_w, r_src_h, r_sx, r_sy;
    logic [AREA_W-1:0] r_area;

    // pixel counters
    logic [DIM_W-1:0] r_src_col, r_src_row, r_ibc, r_ibr;
    logic [DIM_W-1:0] n_src_col, n_src_row, n_ibc, n_ibr;
    logic [COL_W-1:0] r_bc, n_bc;
    logic [ROW_W-1:0] r_br, n_br;

    // per-pixel decisions
    logic              w_accept, w_active, w_first, w_emit, w_last;
    logic [LUMA_W-1:0] w_luma;

    // word in flight
    logic              r_first, r_emit, r_last;
    logic [LUMA_W-1:0] r_luma;
    logic [ADDR_W-1:0] r_addr;
    logic [COORD_W-1:0] r_col, r_row;

    // accumulator RAM
    logic [SUM_W-1:0] w_rd_data, w_sum;
    logic             w_mem_we;

    // divider
    logic [SUM_W-1:0]     r_quo;
    logic [AREA_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [AREA_W:0]      w_rem_sh, w_rem_diff;
    logic                 w_q_bit;

    // output word
    logic               r_out_valid, r_out_last;
    logic [GRAY_W-1:0]  r_out_gray;
    logic [COORD_W-1:0] r_out_col, r_out_row;
    logic               w_out_load;

    // sequencer
    t_state r_state, n_state;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RESET_SRC_W;
            r_src_h <= RESET_SRC_H;
            r_sx    <= RESET_SX;
            r_sy    <= RESET_SY;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SRC_WIDTH: begin
                    r_src_w <= clamp_dim(i_cfg_data);
                    r_sx    <= scale_dim(clamp_dim(i_cfg_data), SX_RECIP);
                end
                CFG_SRC_HEIGHT: begin
                    r_src_h <= clamp_dim(i_cfg_data);
                    r_sy    <= scale_dim(clamp_dim(i_cfg_data), SY_RECIP);
                end
                default: begin
                    r_src_w <= r_src_w;
                end
            endcase
        end
    end

    // block area for the divider
    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(r_sx) * AREA_W'(r_sy);
    end

    // decisions for the incoming pixel
    always_comb begin
        w_luma   = luma_of(i_s_axis_tdata);
        w_active = (r_sx != '0) && (r_sy != '0) &&
                   (r_bc < COL_W'(OUT_W)) && (r_br < ROW_W'(OUT_H));
        w_first  = (r_ibc == '0) && (r_ibr == '0);
        w_emit   = ((DIM_W + 1)'(r_ibc) + (DIM_W + 1)'(1) >= (DIM_W + 1)'(r_sx)) &&
                   ((DIM_W + 1)'(r_ibr) + (DIM_W + 1)'(1) >= (DIM_W + 1)'(r_sy));
        w_last   = (r_bc == COL_W'(OUT_W - 1)) && (r_br == ROW_W'(OUT_H - 1));
    end

    // counter advance
    always_comb begin
        logic [DIM_W:0] col_inc, ibc_inc, row_inc, ibr_inc;
        col_inc   = (DIM_W + 1)'(r_src_col) + (DIM_W + 1)'(1);
        ibc_inc   = (DIM_W + 1)'(r_ibc) + (DIM_W + 1)'(1);
        row_inc   = (DIM_W + 1)'(r_src_row) + (DIM_W + 1)'(1);
        ibr_inc   = (DIM_W + 1)'(r_ibr) + (DIM_W + 1)'(1);
        n_src_col = col_inc[DIM_W-1:0];
        n_ibc     = ibc_inc[DIM_W-1:0];
        n_bc      = r_bc;
        n_src_row = r_src_row;
        n_ibr     = r_ibr;
        n_br      = r_br;
        if (ibc_inc >= (DIM_W + 1)'(r_sx)) begin
            n_ibc = '0;
            if (r_bc < COL_W'(OUT_W)) begin
                n_bc = r_bc + COL_W'(1);
            end
        end
        if (col_inc >= (DIM_W + 1)'(r_src_w)) begin
            n_src_col = '0;
            n_ibc     = '0;
            n_bc      = '0;
            n_src_row = row_inc[DIM_W-1:0];
            n_ibr     = ibr_inc[DIM_W-1:0];
            if (ibr_inc >= (DIM_W + 1)'(r_sy)) begin
                n_ibr = '0;
                if (r_br < ROW_W'(OUT_H)) begin
                    n_br = r_br + ROW_W'(1);
                end
            end
            if (row_inc >= (DIM_W + 1)'(r_src_h)) begin
                n_src_row = '0;
                n_ibr     = '0;
                n_br      = '0;
            end
        end
    end

    // counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_ibc     <= '0;
            r_ibr     <= '0;
            r_bc      <= '0;
            r_br      <= '0;
        end else if (w_accept) begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_ibc     <= n_ibc;
            r_ibr     <= n_ibr;
            r_bc      <= n_bc;
            r_br      <= n_br;
        end
    end

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_luma  <= w_luma;
            r_first <= w_first;
            r_emit  <= w_emit;
            r_last  <= w_last;
            r_addr  <= r_bc[ADDR_W-1:0];
            r_col   <= COORD_W'(r_bc);
            r_row   <= COORD_W'(r_br);
        end
    end

    // column sum update: first pixel of a block overwrites
    assign w_sum = r_first ? SUM_W'(r_luma) : (w_rd_data + SUM_W'(r_luma));

    lbd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (OUT_W)
    ) u_col_sums (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (r_addr),
        .i_wr_data (w_sum),
        .i_rd_addr (r_bc[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // restoring divider step
    always_comb begin
        w_rem_sh   = {r_rem, r_quo[SUM_W-1]};
        w_rem_diff = w_rem_sh - {1'b0, r_area};
        w_q_bit    = !w_rem_diff[AREA_W];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RMW) begin
            r_quo     <= w_sum;
            r_rem     <= '0;
            r_div_cnt <= DIV_CNT_W'(SUM_W - 1);
        end else if (r_state == S_DIV) begin
            r_quo     <= {r_quo[SUM_W-2:0], w_q_bit};
            r_rem     <= w_q_bit ? w_rem_diff[AREA_W-1:0] : w_rem_sh[AREA_W-1:0];
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_active) begin
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                n_state = r_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_mem_we        = 1'b0;
        w_out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: o_s_axis_tready = 1'b1;
            S_RMW:  w_mem_we        = 1'b1;
            S_DIV:  w_out_load      = 1'b0;
            S_OUT:  w_out_load      = !r_out_valid || i_m_axis_tready;
            default: o_s_axis_tready = 1'b0;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_gray <= r_quo[GRAY_W-1:0] - GRAY_BIAS;
            r_out_col  <= r_col;
            r_out_row  <= r_row;
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_row, r_out_col, r_out_gray};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTH
    // a pixel inside a whole block goes to the read-modify-write step
    a_active_to_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_active) |=> (r_state == S_RMW))
        else $error("accepted pixel did not reach the accumulator update");

    // an ignored pixel leaves the sequencer idle
    a_ignored_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_active) |=> (r_state == S_IDLE))
        else $error("ignored pixel started work");

    // the divider only ends into the output step
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> ((r_state == S_DIV) || (r_state == S_OUT)))
        else $error("divider left early");

    // a loaded result shows on the output next cycle
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_m_axis_tvalid && (r_state == S_IDLE)))
        else $error("block result was not presented");
`endif

endmodule

FILE: rtl/lbd_ram.sv
`timescale 1ns / 1ps
// lbd_ram: generic single-write, single-read RAM with registered read data
// depends on nothing; used for the per-column accumulator store

module lbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
